FILE: rtl/ird_pkg.sv
package ird_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int WORD_W = 32;

  localparam logic [1:0] REQ_INSERT    = 2'd0;
  localparam logic [1:0] REQ_POP_FRONT = 2'd1;
  localparam logic [1:0] REQ_POP_REAR  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic accept;
    logic load;
  } ird_cmd_t;

  typedef struct packed {
    logic out_valid;
  } ird_sts_t;

endpackage

FILE: rtl/ird_ctrl.sv
module ird_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_stall,
  input  ird_pkg::ird_sts_t sts,
  output logic              in_stall,
  output ird_pkg::ird_cmd_t cmd
);
  import ird_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOAD = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = !sts.out_valid || !out_stall;
        if (cmd.load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/ird_dp.sv
module ird_dp #(
  parameter int DEPTH = ird_pkg::DEFAULT_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ird_pkg::ird_cmd_t               cmd,
  output ird_pkg::ird_sts_t               sts,
  input  logic [1:0]                      in_req_type,
  input  logic signed [ird_pkg::WORD_W-1:0] in_push_value,
  input  logic                            out_stall,
  output logic signed [ird_pkg::WORD_W-1:0] out_pop_value,
  output logic [1:0]                      out_status,
  output logic                            out_is_full,
  output logic                            out_is_empty
);
  import ird_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_NEG1 = 2'd1;
  localparam logic [1:0] SRC_MEM  = 2'd2;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          empty_r, empty_nxt;

  logic [1:0] pend_src_r, pend_src_nxt;
  logic [1:0] pend_status_r, pend_status_nxt;
  logic       pend_full_r;
  logic       pend_empty_r;

  logic signed [WORD_W-1:0] out_pop_value_r;
  logic [1:0]               out_status_r;
  logic                     out_is_full_r;
  logic                     out_is_empty_r;
  logic                     out_valid_r;

  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] mem_addr;
  logic          full_now;
  logic          full_nxt;

  function automatic logic [AW-1:0] idx_up(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_down(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - AW'(1);
  endfunction

  assign full_now = !empty_r && (head_r == idx_up(tail_r));
  assign full_nxt = !empty_nxt && (head_nxt == idx_up(tail_nxt));

  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    empty_nxt       = empty_r;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    mem_addr        = head_r;
    pend_src_nxt    = SRC_ZERO;
    pend_status_nxt = ST_DONE;
    if (cmd.accept) begin
      unique case (in_req_type) inside
        REQ_INSERT: begin
          if (full_now) begin
            pend_status_nxt = ST_FULL;
          end else begin
            wr_en = 1'b1;
            if (empty_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b0;
            end else begin
              head_nxt = idx_down(head_r);
            end
            mem_addr = head_nxt;
          end
        end
        REQ_POP_FRONT, REQ_POP_REAR: begin
          if (empty_r) begin
            pend_src_nxt    = SRC_NEG1;
            pend_status_nxt = ST_EMPTY;
          end else begin
            rd_en        = 1'b1;
            pend_src_nxt = SRC_MEM;
            mem_addr     = (in_req_type == REQ_POP_FRONT) ? head_r : tail_r;
            if (head_r == tail_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end else if (in_req_type == REQ_POP_FRONT) begin
              head_nxt = idx_up(head_r);
            end else begin
              tail_nxt = idx_down(tail_r);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mem_addr] <= in_push_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_src_r    <= pend_src_nxt;
      pend_status_r <= pend_status_nxt;
      pend_full_r   <= full_nxt;
      pend_empty_r  <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (pend_src_r)
        SRC_MEM:  out_pop_value_r <= rd_data_r;
        SRC_NEG1: out_pop_value_r <= -32'sd1;
        default:  out_pop_value_r <= '0;
      endcase
      out_status_r   <= pend_status_r;
      out_is_full_r  <= pend_full_r;
      out_is_empty_r <= pend_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_valid = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;
  assign out_is_full   = out_is_full_r;
  assign out_is_empty  = out_is_empty_r;

endmodule

FILE: rtl/input_restricted_deque_unit.sv
// A deque of DEPTH signed 32-bit words that takes words in only at the front
// and gives them out at the front or the rear, answering every request with
// exactly one result that carries the removed word, a status code and the
// full and empty flags after the request. The request is taken in S_IDLE,
// where the pointers move and the store is written or read, and the
// registered read data of the single-port store is moved into the output
// register in S_LOAD, which waits while a held result is stalled. A new
// request is taken once the previous result has entered the output register,
// so one result may wait there while the next request is worked on.
module input_restricted_deque_unit #(
  parameter int DEPTH = ird_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic signed [ird_pkg::WORD_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ird_pkg::WORD_W-1:0] out_pop_value,
  output logic [1:0]                        out_status,
  output logic                              out_is_full,
  output logic                              out_is_empty
);
  import ird_pkg::*;

  ird_cmd_t cmd;
  ird_sts_t sts;

  ird_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  ird_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .out_stall     (out_stall),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_is_full   (out_is_full),
    .out_is_empty  (out_is_empty)
  );

  assign out_valid = sts.out_valid;

`ifndef SYNTH
  a_one_per_two: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input transfer in back-to-back cycles");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_full && out_is_empty))
    else $error("result flags show full and empty together");

  a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_pop_value == -32'sd1 && out_is_empty))
    else $error("empty refusal without -1 data or empty flag");
`endif

endmodule
